// ----- design/lfpd_pkg.sv -----
// shared constants, types and helpers of the line follower pid drive
package lfpd_pkg;

    localparam int NUM_SENSORS = 8;
    localparam int SAMPLE_BITS = 8;
    localparam int SUM_BITS    = 24;

    localparam int IDX_W      = $clog2(NUM_SENSORS);
    localparam int ERR_W      = IDX_W + 1;
    localparam int DIF_W      = ERR_W + 1;
    localparam int GAIN_W     = 24;
    localparam int DRV_W      = 16;
    localparam int P_W        = GAIN_W + 1 + ERR_W;
    localparam int D_W        = GAIN_W + 1 + DIF_W;
    localparam int I_W        = GAIN_W + 1 + SUM_BITS;
    localparam int ACC_W      = I_W + 2;
    localparam int ROUND_SHIFT = 8;
    localparam int PID_W      = ACC_W - ROUND_SHIFT;
    localparam int DSUM_W     = PID_W + 1;

    localparam int SAMPLES_W    = NUM_SENSORS * SAMPLE_BITS;
    localparam int IN_TDATA_W   = ((SAMPLES_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * DRV_W + IDX_W + ERR_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_SEL_W  = 2;

    localparam logic [REG_SEL_W-1:0] REG_BASE_SPEED = 2'd0;
    localparam logic [REG_SEL_W-1:0] REG_PROP_GAIN  = 2'd1;
    localparam logic [REG_SEL_W-1:0] REG_DERIV_GAIN = 2'd2;
    localparam logic [REG_SEL_W-1:0] REG_INTEG_GAIN = 2'd3;

    localparam logic signed [DRV_W-1:0] BASE_SPEED_RST = 16'sd5120;
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 24'd936229;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 24'd46811;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 24'd94;

    localparam logic signed [SUM_BITS:0] SUM_MAX =
        (SUM_BITS+1)'((64'sd1 <<< (SUM_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_BITS:0] SUM_MIN =
        (SUM_BITS+1)'(-(64'sd1 <<< (SUM_BITS - 1)));

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(128);

    localparam logic signed [DSUM_W-1:0] DRV_MAX = DSUM_W'(32767);
    localparam logic signed [DSUM_W-1:0] DRV_MIN = DSUM_W'(-32768);

    typedef struct packed {
        logic signed [DRV_W-1:0] base_speed;
        logic [GAIN_W-1:0]       prop_gain;
        logic [GAIN_W-1:0]       deriv_gain;
        logic [GAIN_W-1:0]       integ_gain;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0]           idx;
        logic signed [ERR_W-1:0]    err;
        logic signed [DIF_W-1:0]    diff;
        logic signed [SUM_BITS-1:0] sum;
    } t_err_item;

    function automatic logic signed [DRV_W-1:0] sat_drive(input logic signed [DSUM_W-1:0] v);
        logic signed [DRV_W-1:0] res;
        if (v > DRV_MAX) begin
            res = DRV_MAX[DRV_W-1:0];
        end else if (v < DRV_MIN) begin
            res = DRV_MIN[DRV_W-1:0];
        end else begin
            res = v[DRV_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- design/lfpd_cfg.sv -----
// apb register file holding drive speed and pid gains
module lfpd_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lfpd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lfpd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lfpd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output lfpd_pkg::t_cfg                  o_cfg
);
    import lfpd_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_SEL_W-1:0] sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = paddr[REG_SEL_W+1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_speed <= BASE_SPEED_RST;
            r_cfg.prop_gain  <= PROP_GAIN_RST;
            r_cfg.deriv_gain <= DERIV_GAIN_RST;
            r_cfg.integ_gain <= INTEG_GAIN_RST;
        end else if (wr_en) begin
            case (sel)
                REG_BASE_SPEED: r_cfg.base_speed <= pwdata[DRV_W-1:0];
                REG_PROP_GAIN:  r_cfg.prop_gain  <= pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN: r_cfg.deriv_gain <= pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN: r_cfg.integ_gain <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_BASE_SPEED: prdata = APB_DATA_W'(unsigned'(r_cfg.base_speed));
            REG_PROP_GAIN:  prdata = APB_DATA_W'(r_cfg.prop_gain);
            REG_DERIV_GAIN: prdata = APB_DATA_W'(r_cfg.deriv_gain);
            REG_INTEG_GAIN: prdata = APB_DATA_W'(r_cfg.integ_gain);
            default:        prdata = '0;
        endcase
    end

endmodule

// ----- design/lfpd_err.sv -----
// sample register, darkest sensor search, error and saturating integrator
module lfpd_err (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [lfpd_pkg::SAMPLES_W-1:0] i_samples,
    output logic                           o_valid,
    input  logic                           i_ready,
    output lfpd_pkg::t_err_item            o_item
);
    import lfpd_pkg::*;

    logic                        r_in_valid;
    logic [SAMPLES_W-1:0]        r_samples;
    logic                        r_b_valid;
    t_err_item                   r_b_item;
    logic signed [ERR_W-1:0]     r_prev_error;
    logic signed [SUM_BITS-1:0]  r_error_sum;

    logic                        b_ready;
    logic                        a_fire;
    logic [IDX_W-1:0]            idx;
    logic signed [ERR_W:0]       err_wide;
    logic signed [ERR_W-1:0]     err;
    logic signed [DIF_W-1:0]     diff;
    logic signed [SUM_BITS:0]    sum_wide;
    logic signed [SUM_BITS-1:0]  n_error_sum;

    assign b_ready = !r_b_valid || i_ready;
    assign a_fire  = r_in_valid && b_ready;
    assign o_ready = !r_in_valid || b_ready;
    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

    // strict compare keeps the first maximum, all zero gives index zero
    always_comb begin
        logic [SAMPLE_BITS-1:0] best;
        logic [SAMPLE_BITS-1:0] cur;
        best = '0;
        idx  = '0;
        for (int k = 0; k < NUM_SENSORS; k++) begin
            cur = r_samples[k*SAMPLE_BITS +: SAMPLE_BITS];
            if (cur > best) begin
                best = cur;
                idx  = IDX_W'(k);
            end
        end
    end

    always_comb begin
        err_wide = $signed({1'b0, idx, 1'b0}) - $signed((ERR_W+1)'(NUM_SENSORS - 1));
        err      = err_wide[ERR_W-1:0];
        diff     = DIF_W'(err) - DIF_W'(r_prev_error);
        sum_wide = (SUM_BITS+1)'(r_error_sum) + (SUM_BITS+1)'(err);
        if (sum_wide > SUM_MAX) begin
            n_error_sum = SUM_MAX[SUM_BITS-1:0];
        end else if (sum_wide < SUM_MIN) begin
            n_error_sum = SUM_MIN[SUM_BITS-1:0];
        end else begin
            n_error_sum = sum_wide[SUM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_b_valid    <= 1'b0;
            r_prev_error <= '0;
            r_error_sum  <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (a_fire) begin
                r_in_valid <= 1'b0;
            end
            if (a_fire) begin
                r_b_valid    <= 1'b1;
                r_prev_error <= err;
                r_error_sum  <= n_error_sum;
            end else if (i_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_samples <= i_samples;
        end
        if (a_fire) begin
            r_b_item.idx  <= idx;
            r_b_item.err  <= err;
            r_b_item.diff <= diff;
            r_b_item.sum  <= n_error_sum;
        end
    end

endmodule

// ----- design/lfpd_pid.sv -----
// pid products, rounding and drive saturation with output register
module lfpd_pid (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lfpd_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  lfpd_pkg::t_err_item           i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [lfpd_pkg::DRV_W-1:0] o_left_drive,
    output logic signed [lfpd_pkg::DRV_W-1:0] o_right_drive,
    output logic [lfpd_pkg::IDX_W-1:0]    o_darkest_index,
    output logic signed [lfpd_pkg::ERR_W-1:0] o_line_error
);
    import lfpd_pkg::*;

    logic                     r_c_valid;
    logic signed [P_W-1:0]    r_prod_p;
    logic signed [D_W-1:0]    r_prod_d;
    logic signed [I_W-1:0]    r_prod_i;
    logic [IDX_W-1:0]         r_c_idx;
    logic signed [ERR_W-1:0]  r_c_err;

    logic                     r_o_valid;
    logic signed [DRV_W-1:0]  r_left;
    logic signed [DRV_W-1:0]  r_right;
    logic [IDX_W-1:0]         r_idx;
    logic signed [ERR_W-1:0]  r_err;

    logic                     out_ready;
    logic                     c_fire;
    logic                     b_fire;
    logic signed [P_W-1:0]    prod_p;
    logic signed [D_W-1:0]    prod_d;
    logic signed [I_W-1:0]    prod_i;
    logic signed [ACC_W-1:0]  acc;
    logic signed [PID_W-1:0]  pid;
    logic signed [DSUM_W-1:0] base_ext;
    logic signed [DSUM_W-1:0] left_sum;
    logic signed [DSUM_W-1:0] right_sum;

    assign out_ready = !r_o_valid || i_ready;
    assign c_fire    = r_c_valid && out_ready;
    assign o_ready   = !r_c_valid || out_ready;
    assign b_fire    = i_valid && o_ready;

    assign o_valid         = r_o_valid;
    assign o_left_drive    = r_left;
    assign o_right_drive   = r_right;
    assign o_darkest_index = r_idx;
    assign o_line_error    = r_err;

    always_comb begin
        prod_p = $signed({1'b0, i_cfg.prop_gain}) * i_item.err;
        prod_d = $signed({1'b0, i_cfg.deriv_gain}) * i_item.diff;
        prod_i = $signed({1'b0, i_cfg.integ_gain}) * i_item.sum;
    end

    // round half up to q8.8: bias then keep the upper bits (floor)
    always_comb begin
        acc       = ACC_W'(r_prod_p) + ACC_W'(r_prod_d) + ACC_W'(r_prod_i) + ROUND_BIAS;
        pid       = acc[ACC_W-1:ROUND_SHIFT];
        base_ext  = DSUM_W'(i_cfg.base_speed);
        left_sum  = base_ext + DSUM_W'(pid);
        right_sum = base_ext - DSUM_W'(pid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (b_fire) begin
                r_c_valid <= 1'b1;
            end else if (out_ready) begin
                r_c_valid <= 1'b0;
            end
            if (c_fire) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_prod_p <= prod_p;
            r_prod_d <= prod_d;
            r_prod_i <= prod_i;
            r_c_idx  <= i_item.idx;
            r_c_err  <= i_item.err;
        end
        if (c_fire) begin
            r_left  <= sat_drive(left_sum);
            r_right <= sat_drive(right_sum);
            r_idx   <= r_c_idx;
            r_err   <= r_c_err;
        end
    end

endmodule

// ----- design/line_follower_pid_drive.sv -----
// top level of the line follower pid drive
// Each item is one frame of eight 8-bit line-sensor samples (s0 in the lowest
// byte of s_axis_tdata). The block finds the first darkest sensor, forms the
// error 2*index-7, keeps the previous error and a saturating 24-bit error sum,
// and returns left = base+pid and right = base-pid in signed Q8.8, saturated,
// together with the index and the error. One item is taken every clock cycle
// while m_axis_tready does not stall the output; each result passes the four
// register levels: sample register, error/integrator register, product
// register and output register. The integrator state updates only in the
// error/integrator register, fed from the sample register, which bounds the loop.
// The user must write gains and base speed over the apb port while the block is idle; the block does not enforce it.
module line_follower_pid_drive (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lfpd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lfpd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lfpd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // s0, s1, s2, s3, s4, s5, s6, s7
    input  logic [lfpd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // left_drive, right_drive, darkest_index, line_error, zero fill
    output logic [lfpd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import lfpd_pkg::*;

    t_cfg                    cfg;
    logic                    err_valid;
    logic                    err_ready;
    t_err_item               err_item;
    logic signed [DRV_W-1:0] left_drive;
    logic signed [DRV_W-1:0] right_drive;
    logic [IDX_W-1:0]        darkest_index;
    logic signed [ERR_W-1:0] line_error;

    lfpd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lfpd_err u_err (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_samples (s_axis_tdata[SAMPLES_W-1:0]),
        .o_valid   (err_valid),
        .i_ready   (err_ready),
        .o_item    (err_item)
    );

    lfpd_pid u_pid (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (err_valid),
        .o_ready         (err_ready),
        .i_item          (err_item),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_left_drive    (left_drive),
        .o_right_drive   (right_drive),
        .o_darkest_index (darkest_index),
        .o_line_error    (line_error)
    );

    assign m_axis_tdata = OUT_TDATA_W'({line_error, darkest_index, right_drive, left_drive});

endmodule
